// ===== design/kdsk_pkg.sv =====
// kdsk_pkg: shared types and constants of the k-d super key partition block
// beat structs for both channels and the stage one record handed to the merge
// no dependencies
`default_nettype none

package kdsk_pkg;

    localparam int NumCoords  = 4;
    localparam int CoordWidth = 32;
    localparam int IdxWidth   = 16;
    localparam int DimsWidth  = 3;
    localparam int SelWidth   = 2;

    typedef enum logic [0:0] {
        CMD_LOAD     = 1'b0,
        CMD_CLASSIFY = 1'b1
    } kdsk_cmd_t;

    typedef logic signed [CoordWidth-1:0] coord_t;

    typedef struct packed {
        kdsk_cmd_t             command;
        logic [IdxWidth-1:0]   point_index;
        coord_t                coord_0;
        coord_t                coord_1;
        coord_t                coord_2;
        coord_t                coord_3;
        logic [SelWidth-1:0]   key_dim;
        logic [IdxWidth-1:0]   left_start;
        logic [IdxWidth-1:0]   right_start;
        logic                  last_point;
    } kdsk_in_t;

    typedef struct packed {
        logic                  skipped;
        logic                  goes_right;
        logic [IdxWidth-1:0]   write_address;
        logic [IdxWidth-1:0]   point_out;
        logic [IdxWidth-1:0]   left_total;
        logic [IdxWidth-1:0]   right_total;
        logic                  done_res;
    } kdsk_out_t;

    // lane verdicts and side data of one beat, between compare and merge stages
    typedef struct packed {
        logic                  is_load;
        logic                  skip;
        logic [SelWidth-1:0]   prim;
        logic [NumCoords-1:0]  lt;
        logic [NumCoords-1:0]  eq;
        logic                  pid_lt;
        logic [IdxWidth-1:0]   pid;
        logic                  last;
        logic [IdxWidth-1:0]   left_start;
        logic [IdxWidth-1:0]   right_start;
    } kdsk_s1_t;

endpackage

`default_nettype wire

// ===== design/kdsk_lane.sv =====
// kdsk_lane: one coordinate lane, compares a point coordinate with the median's
// signed Q16.16 values compared exactly
// depends on kdsk_pkg
`default_nettype none

module kdsk_lane (
    input  wire kdsk_pkg::coord_t point_coord,
    input  wire kdsk_pkg::coord_t median_coord,
    output logic                  less,
    output logic                  equal
);
    import kdsk_pkg::*;

    always_comb
    begin
        less  = (point_coord < median_coord);
        equal = (point_coord == median_coord);
    end

endmodule

`default_nettype wire

// ===== design/kdsk_merge.sv =====
// kdsk_merge: merging stage, resolves the super key order from the lane verdicts,
// keeps the side counters and base addresses and holds the result register
// depends on kdsk_pkg
`default_nettype none

module kdsk_merge #(
    parameter int CountLimit = 65535
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   s1_valid,
    input  wire kdsk_pkg::kdsk_s1_t s1,
    output logic                  s1_take,
    output logic                  out_valid,
    input  wire                   out_ready,
    output kdsk_pkg::kdsk_out_t   out_data
);
    import kdsk_pkg::*;

    localparam logic [IdxWidth-1:0] Limit = IdxWidth'(CountLimit);

    logic [IdxWidth-1:0] left_cnt_reg, left_cnt_next;
    logic [IdxWidth-1:0] right_cnt_reg, right_cnt_next;
    logic [IdxWidth-1:0] left_org_reg, left_org_next;
    logic [IdxWidth-1:0] right_org_reg, right_org_next;
    logic                out_valid_reg, out_valid_next;
    kdsk_out_t           out_reg, out_next;
    logic                to_left;
    logic                decided;

    // primary lane first, then the other lanes in ascending order, then the index
    always_comb
    begin
        decided = 1'b0;
        to_left = s1.pid_lt;
        if (!s1.eq[s1.prim])
        begin
            decided = 1'b1;
            to_left = s1.lt[s1.prim];
        end
        for (int d = 0; d < NumCoords; d++)
        begin
            if (!decided && (SelWidth'(d) != s1.prim) && !s1.eq[d])
            begin
                decided = 1'b1;
                to_left = s1.lt[d];
            end
        end
    end

    // a load never needs the result slot
    assign s1_take = s1_valid && (s1.is_load || !out_valid_reg || out_ready);

    always_comb
    begin
        left_cnt_next  = left_cnt_reg;
        right_cnt_next = right_cnt_reg;
        left_org_next  = left_org_reg;
        right_org_next = right_org_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        if (s1_take)
        begin
            if (s1.is_load)
            begin
                left_org_next  = s1.left_start;
                right_org_next = s1.right_start;
                left_cnt_next  = '0;
                right_cnt_next = '0;
            end
            else
            begin
                out_valid_next         = 1'b1;
                out_next.point_out     = s1.pid;
                out_next.done_res      = s1.last;
                out_next.skipped       = s1.skip;
                out_next.goes_right    = 1'b0;
                out_next.write_address = '0;
                if (!s1.skip)
                begin
                    if (to_left)
                    begin
                        out_next.write_address = left_org_reg + left_cnt_reg;
                        if (left_cnt_reg < Limit)
                        begin
                            left_cnt_next = left_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        out_next.goes_right    = 1'b1;
                        out_next.write_address = right_org_reg + right_cnt_reg;
                        if (right_cnt_reg < Limit)
                        begin
                            right_cnt_next = right_cnt_reg + 1'b1;
                        end
                    end
                end
                out_next.left_total  = left_cnt_next;
                out_next.right_total = right_cnt_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
            left_org_reg  <= '0;
            right_org_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_cnt_reg  <= left_cnt_next;
            right_cnt_reg <= right_cnt_next;
            left_org_reg  <= left_org_next;
            right_org_reg <= right_org_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ===== design/kd_superkey_partition_core.sv =====
// kd_superkey_partition_core: top level of the k-d super key partition block
// four compare lanes, stage one register and the merging stage
// depends on kdsk_pkg, kdsk_lane, kdsk_merge
//
// A load beat (command 0) stores the median point, split dimension and both base
// addresses and clears the side counters; it gives no result. Each classify beat
// (command 1) gives one result: the median itself is reported as skipped, any
// other point goes left when its super key (split dimension, then the remaining
// active dimensions in ascending order, then the point index) is below the
// median's, and right otherwise, with its write address and the running totals.
// The block takes one beat per cycle while the output is not stalled; a beat is
// registered in stage one, its result in the output register, and while a result
// waits there one more classify beat can enter stage one before the input stalls.
// The rate is set by the merging stage, where the side counter of one point must
// be updated before the next point's address is formed. Counters saturate at
// MAX_POINTS - 1 (at most 65535). Users must write num_dims only while idle; unchecked.
`default_nettype none

module kd_superkey_partition_core #(
    parameter int MAX_DIMS   = 4,
    parameter int MAX_POINTS = 65536
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_wr_en,
    input  wire [kdsk_pkg::DimsWidth-1:0] cfg_wr_data,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire kdsk_pkg::kdsk_in_t      in_data,
    output logic                         out_valid,
    input  wire                          out_ready,
    output kdsk_pkg::kdsk_out_t          out_data
);
    import kdsk_pkg::*;

    localparam int DimLimit   = (MAX_DIMS < NumCoords) ? MAX_DIMS : NumCoords;
    localparam int CountLimit = (MAX_POINTS - 1 > 65535) ? 65535 : MAX_POINTS - 1;

    logic [DimsWidth-1:0] num_dims_reg;
    logic [DimsWidth-1:0] active_dims;
    coord_t               median_coords_reg [NumCoords];
    coord_t               point_coords [NumCoords];
    logic [IdxWidth-1:0]  median_id_reg;
    logic [SelWidth-1:0]  primary_dim_reg;
    logic [NumCoords-1:0] lane_lt;
    logic [NumCoords-1:0] lane_eq;
    logic                 in_take;
    logic                 is_load;
    logic                 s1_valid_reg, s1_valid_next;
    kdsk_s1_t             s1_reg, s1_next;
    logic                 s1_take;

    assign point_coords[0] = in_data.coord_0;
    assign point_coords[1] = in_data.coord_1;
    assign point_coords[2] = in_data.coord_2;
    assign point_coords[3] = in_data.coord_3;

    for (genvar g = 0; g < NumCoords; g++)
    begin : g_lane
        kdsk_lane u_lane (
            .point_coord  (point_coords[g]),
            .median_coord (median_coords_reg[g]),
            .less         (lane_lt[g]),
            .equal        (lane_eq[g])
        );
    end

    always_comb
    begin
        if (num_dims_reg == '0)
        begin
            active_dims = DimsWidth'(1);
        end
        else if (num_dims_reg > DimsWidth'(DimLimit))
        begin
            active_dims = DimsWidth'(DimLimit);
        end
        else
        begin
            active_dims = num_dims_reg;
        end
    end

    assign in_ready = !s1_valid_reg || s1_take;
    assign in_take  = in_valid && in_ready;
    assign is_load  = (in_data.command == CMD_LOAD);

    always_comb
    begin
        s1_next.is_load     = is_load;
        s1_next.skip        = (in_data.point_index == median_id_reg);
        s1_next.prim        = primary_dim_reg;
        s1_next.lt          = lane_lt;
        s1_next.pid_lt      = (in_data.point_index < median_id_reg);
        s1_next.pid         = in_data.point_index;
        s1_next.last        = in_data.last_point;
        s1_next.left_start  = in_data.left_start;
        s1_next.right_start = in_data.right_start;
        // inactive lanes other than the primary one count as ties
        for (int d = 0; d < NumCoords; d++)
        begin
            s1_next.eq[d] = lane_eq[d]
                || ((DimsWidth'(d) >= active_dims) && (SelWidth'(d) != primary_dim_reg));
        end
        s1_valid_next = in_take || (s1_valid_reg && !s1_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg    <= DimsWidth'(2);
            median_id_reg   <= '0;
            primary_dim_reg <= '0;
            s1_valid_reg    <= 1'b0;
            for (int d = 0; d < NumCoords; d++)
            begin
                median_coords_reg[d] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (cfg_wr_en)
            begin
                num_dims_reg <= cfg_wr_data;
            end
            // median takes effect for the very next beat's lane compare
            if (in_take && is_load)
            begin
                median_id_reg   <= in_data.point_index;
                primary_dim_reg <= in_data.key_dim;
                for (int d = 0; d < NumCoords; d++)
                begin
                    median_coords_reg[d] <= point_coords[d];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_reg <= s1_next;
        end
    end

    kdsk_merge #(
        .CountLimit (CountLimit)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid_reg),
        .s1        (s1_reg),
        .s1_take   (s1_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_skip_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.skipped |-> !out_data.goes_right && out_data.write_address == '0)
        else $error("skipped result carries a side or address");

    a_left_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.skipped && !out_data.goes_right |-> out_data.left_total != '0)
        else $error("left point not counted");

    a_right_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.skipped && out_data.goes_right |-> out_data.right_total != '0)
        else $error("right point not counted");

    a_total_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.left_total <= IdxWidth'(CountLimit)
            && out_data.right_total <= IdxWidth'(CountLimit))
        else $error("side total above saturation limit");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && !s1_reg.is_load)
        else $error("input stalled without a pending classify beat");

endmodule

`default_nettype wire
